FILE: rtl/core/prfd_pkg.sv
// Package for the packet relay filter: verdict codes, defaults and the CRC-32 byte step.
`default_nettype none
package prfd_pkg;

  typedef enum logic [2:0] {
    V_RELAY  = 3'd0,
    V_SHORT  = 3'd1,
    V_FORMAT = 3'd2,
    V_HOPS   = 3'd3,
    V_DUP    = 3'd4,
    V_LONG   = 3'd5
  } verdict_e;

  localparam int unsigned DEDUP_ENTRIES_DEF = 32;
  localparam int unsigned MAX_LEN_DEF       = 255;

  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [8:0]  COUNT_CAP  = 9'd256;
  localparam int unsigned FORMAT_BIT = 7;

  localparam logic [7:0]  HOP_LIMIT_RST = 8'd16;
  localparam logic [31:0] TTL_RST       = 32'd10000;

  localparam int unsigned PADDR_BITS    = 3;
  localparam logic        REG_HOP_LIMIT = 1'b0;
  localparam logic        REG_TTL       = 1'b1;

  // Reflected CRC-32, one byte, bit at a time.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/packet_relay_filter_dedup.sv
// Packet relay filter: byte-wise CRC-32 front end and a ring-memory duplicate scan.
// Path: a drop decided by length, format or hop limit passes from the job slot through the
// IDLE and RESULT states to the output register; a relay candidate first scans every ring entry.
// Throughput: one byte per cycle; the last byte of a packet waits while the previous
// packet's job is still held, and the job stays held while the scan walks every entry
// through the single read port of the ring memory, once per entry.
// Reset: asynchronous, active low; clears control, CRC, registers and the ring valid bits.
`default_nettype none
module packet_relay_filter_dedup #(
  parameter int unsigned DEDUP_ENTRIES = prfd_pkg::DEDUP_ENTRIES_DEF,
  parameter int unsigned MAX_LEN       = prfd_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [31:0] now_ms_i,
  // verdict output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       verdict_o,
  output logic [7:0]       new_hop_count_o,
  output logic [31:0]      packet_hash_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [prfd_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import prfd_pkg::*;

  localparam int unsigned IDXW = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(DEDUP_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so a write completes on the
  // access phase. Only the word index (paddr[2]) selects the register.
  // ---------------------------------------------------------------------------
  logic [7:0]  hop_limit_q;
  logic [31:0] ttl_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_limit_q <= HOP_LIMIT_RST;
      ttl_q       <= TTL_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_HOP_LIMIT) hop_limit_q <= pwdata[7:0];
      else                           ttl_q       <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_TTL) ? ttl_q : {24'd0, hop_limit_q};

  // ---------------------------------------------------------------------------
  // Front end: one byte per transfer. Run the CRC, count bytes (saturating),
  // keep the marker and hop bytes. On the last byte, hand a job to the back end
  // and return to the start-of-packet state.
  // ---------------------------------------------------------------------------
  logic [31:0] crc_q, crc_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  marker_q, marker_d;
  logic [7:0]  hop_q, hop_d;
  logic        in_xfer;

  // job slot between front end and scan
  logic        job_vld_q;
  logic [31:0] job_hash_q;
  logic        job_long_q;
  logic        job_short_q;
  logic        job_fmt_q;
  logic [7:0]  job_hop_q;
  logic [31:0] job_now_q;
  logic        job_done;

  // A last byte needs a free job slot; other bytes always flow.
  assign in_ready_o = !job_vld_q || !last_byte_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    crc_d    = crc_feed(crc_q, data_byte_i);
    cnt_d    = (cnt_q == COUNT_CAP) ? cnt_q : cnt_q + 9'd1;
    marker_d = (cnt_q == 9'd0) ? data_byte_i : marker_q;
    hop_d    = (cnt_q == 9'd1) ? data_byte_i : hop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      cnt_q    <= '0;
      marker_q <= '0;
      hop_q    <= '0;
    end else if (in_xfer) begin
      if (last_byte_i) begin
        crc_q    <= CRC_INIT;
        cnt_q    <= '0;
        marker_q <= '0;
        hop_q    <= '0;
      end else begin
        crc_q    <= crc_d;
        cnt_q    <= cnt_d;
        marker_q <= marker_d;
        hop_q    <= hop_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
    end else if (in_xfer && last_byte_i) begin
      job_vld_q <= 1'b1;
    end else if (job_done) begin
      job_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_byte_i) begin
      job_hash_q  <= ~crc_d;
      job_long_q  <= cnt_d > 9'(MAX_LEN);
      job_short_q <= cnt_d < 9'd2;
      job_fmt_q   <= marker_d[FORMAT_BIT];
      job_hop_q   <= hop_d;
      job_now_q   <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Back end: ring of {hash, time} in a synchronous memory, one read a cycle.
  // IDLE applies the cheap checks; SCAN walks every entry and accumulates a
  // hit; RESULT loads the output register and, on relay, writes the ring.
  // Entries never written read as hash zero, time zero through the valid bits.
  // ---------------------------------------------------------------------------
  logic [63:0]              ring_mem [DEDUP_ENTRIES];
  logic [DEDUP_ENTRIES-1:0] ent_vld_q;
  logic [IDXW-1:0]          ring_pos_q;

  logic [1:0]      state_q;
  logic [CNTW-1:0] scan_cnt_q;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic [63:0]     rd_ent_q;
  logic            rd_ent_vld_q;
  logic            rd_vld_q;
  logic [31:0]     rd_hash, rd_time;
  logic            match;
  logic            hit_q;
  verdict_e        pre_verdict_q;
  verdict_e        pre_verdict;
  verdict_e        fin_verdict;
  logic            out_load;
  logic            ring_we;

  assign rd_en   = (state_q == ST_SCAN) && (scan_cnt_q < CNTW'(DEDUP_ENTRIES));
  assign rd_addr = scan_cnt_q[IDXW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_ent_q <= ring_mem[rd_addr];
    end
    if (ring_we) begin
      ring_mem[ring_pos_q] <= {job_hash_q, job_now_q};
    end
  end

  assign rd_hash = rd_ent_vld_q ? rd_ent_q[63:32] : 32'd0;
  assign rd_time = rd_ent_vld_q ? rd_ent_q[31:0]  : 32'd0;
  // wrapping age against the TTL; a zero TTL never matches
  assign match   = rd_vld_q && (rd_hash == job_hash_q) && ((job_now_q - rd_time) < ttl_q);

  always_comb begin
    if (job_long_q)                   pre_verdict = V_LONG;
    else if (job_short_q)             pre_verdict = V_SHORT;
    else if (!job_fmt_q)              pre_verdict = V_FORMAT;
    else if (job_hop_q >= hop_limit_q) pre_verdict = V_HOPS;
    else                              pre_verdict = V_RELAY;
  end

  assign fin_verdict = (pre_verdict_q == V_RELAY && hit_q) ? V_DUP : pre_verdict_q;
  assign out_load    = (state_q == ST_RESULT) && (!out_valid_o || out_ready_i);
  assign ring_we     = out_load && (fin_verdict == V_RELAY);
  assign job_done    = out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_cnt_q    <= '0;
      rd_vld_q      <= 1'b0;
      rd_ent_vld_q  <= 1'b0;
      hit_q         <= 1'b0;
      pre_verdict_q <= V_RELAY;
      ent_vld_q     <= '0;
      ring_pos_q    <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) begin
        rd_ent_vld_q <= ent_vld_q[rd_addr];
      end
      case (state_q)
        ST_IDLE: begin
          if (job_vld_q) begin
            pre_verdict_q <= pre_verdict;
            hit_q         <= 1'b0;
            scan_cnt_q    <= '0;
            state_q       <= (pre_verdict == V_RELAY) ? ST_SCAN : ST_RESULT;
          end
        end
        ST_SCAN: begin
          // fold in the entry read last cycle; finish once the last one is compared
          hit_q <= hit_q || match;
          if (scan_cnt_q == CNTW'(DEDUP_ENTRIES)) begin
            state_q <= ST_RESULT;
          end else begin
            scan_cnt_q <= scan_cnt_q + CNTW'(1);
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (ring_we) begin
        ent_vld_q[ring_pos_q] <= 1'b1;
        ring_pos_q <= (ring_pos_q == IDXW'(DEDUP_ENTRIES - 1)) ? '0 : ring_pos_q + IDXW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the verdict until transfer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_o       <= fin_verdict;
      new_hop_count_o <= (fin_verdict == V_RELAY) ? job_hop_q + 8'd1 : 8'd0;
      packet_hash_o   <= job_hash_q;
    end
  end

`ifndef SYNTHESIS
  // a last byte only enters a free job slot
  a_job_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |-> !job_vld_q)
    else $error("last byte accepted while job slot busy");

  // the scan and result states always work on a held job
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_RESULT) |-> job_vld_q)
    else $error("back end active without a job");

  // only relayed packets are written into the ring
  a_ring_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (pre_verdict_q == V_RELAY && !hit_q))
    else $error("ring written for a dropped packet");

  // a relayed hop count is below the hop limit, so its increment never wraps
  a_relay_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == V_RELAY) |-> (new_hop_count_o != 8'd0))
    else $error("relayed hop count wrapped");

  // the scan counter stops at the entry count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q <= CNTW'(DEDUP_ENTRIES))
    else $error("scan counter overran");
`endif

endmodule
`default_nettype wire
